// ----- rtl/tds_pkg.sv -----
// Package for the tridiagonal system solver: parameter defaults, the
// saturating helpers of the sequencer and the divider result type.
// No dependencies.
`default_nettype none
package tds_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int ROW_IDX_W     = 5;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Saturate a 33-bit sum to 32 bits.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = SAT_MAX;
        else if (v < -33'sh0_8000_0000)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Floor-shift a full product by the fraction width, then saturate.
    function automatic logic signed [31:0] mul_shift(input logic signed [63:0] p,
                                                     input int frac);
        logic signed [63:0] s;
        logic signed [31:0] r;
        s = p >>> frac;
        if (s > 64'sh0000_0000_7FFF_FFFF)
            r = SAT_MAX;
        else if (s < -64'sh0000_0000_8000_0000)
            r = SAT_MIN;
        else
            r = s[31:0];
        return r;
    endfunction

    typedef struct packed {
        logic               done;
        logic               zero;
        logic signed [31:0] quot;
    } div_res_t;

endpackage
`default_nettype wire

// ----- rtl/tds_if.sv -----
// Valid/ready channel interfaces of the tridiagonal solver: the row request
// channel and the solution result channel. No dependencies.
`default_nettype none
interface tds_row_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    output ready);
endinterface

interface tds_sol_if;
    logic               valid;
    logic               ready;
    logic        [4:0]  row_index;
    logic signed [31:0] solution;
    logic               last_result;
    logic               singular;
    logic               overflow;

    modport source (output valid, row_index, solution, last_result, singular, overflow,
                    input ready);
    modport sink   (input valid, row_index, solution, last_result, singular, overflow,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/tridiagonal_system_solver.sv -----
// Tridiagonal solver (Thomas algorithm), signed fixed point, one row at a time.
// Forward row: read the stores, multiply, form pivot and numerator (not on the first
// row), then two serial divides, factor then offset, each waiting on the divider.
// Back substitution: read, multiply and add through one multiplier, emit on ready.
// Reset (rst_n, async low) clears sequencer, row count and flags; stores are not cleared.
// Depends on tds_pkg, tds_if, tds_divider.
`default_nettype none
module tridiagonal_system_solver
    import tds_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    tds_row_if.sink   row_in,
    tds_sol_if.source sol_out
);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_PIV, S_NUM, S_DIVV_GO, S_DIVV,
        S_DIVU_GO, S_DIVU, S_EMIT, S_BRD, S_BMUL, S_BADD
    } state_t;

    state_t state_reg;

    logic [IW-1:0] idx_reg, r_reg;
    logic          sing_reg, ovf_reg, last_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [31:0] pivot_reg, numer_reg, x_reg;
    logic signed [63:0] p_reg;

    logic signed [31:0] fac_mem [DEPTH];
    logic signed [31:0] off_mem [DEPTH];
    logic signed [31:0] fac_rd_reg, off_rd_reg;
    logic [IW-1:0]      rd_addr;
    logic               fac_we, off_we;

    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] prod_sh;
    logic               div_start;
    logic signed [32:0] div_num;
    div_res_t           div_res;

    tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (pivot_reg),
        .res   (div_res)
    );

    always_comb
    begin
        prod_sh   = mul_shift(p_reg, FRAC_BITS);
        div_start = (state_reg == S_DIVV_GO) || (state_reg == S_DIVU_GO);
        div_num   = (state_reg == S_DIVV_GO) ? -$signed({c_reg[31], c_reg})
                                             : $signed({numer_reg[31], numer_reg});
        rd_addr   = (state_reg == S_RD) ? idx_reg - 1'b1 : r_reg;
        fac_we    = (state_reg == S_DIVV) && div_res.done;
        off_we    = (state_reg == S_DIVU) && div_res.done;
        case (state_reg)
            S_MUL:   begin mul_a = a_reg;      mul_b = fac_rd_reg; end
            S_PIV:   begin mul_a = a_reg;      mul_b = off_rd_reg; end
            default: begin mul_a = fac_rd_reg; mul_b = x_reg;      end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fac_we)
            fac_mem[idx_reg] <= div_res.quot;
        if (off_we)
            off_mem[idx_reg] <= div_res.quot;
        fac_rd_reg <= fac_mem[rd_addr];
        off_rd_reg <= off_mem[rd_addr];
        p_reg      <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            r_reg     <= '0;
            sing_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            pivot_reg <= '0;
            numer_reg <= '0;
            x_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (row_in.valid)
                    begin
                        pivot_reg <= row_in.main_diag;
                        numer_reg <= row_in.rhs;
                        state_reg <= (idx_reg == '0) ? S_DIVV_GO : S_RD;
                    end
                end
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_PIV;
                S_PIV:
                begin
                    pivot_reg <= sat33($signed({b_reg[31], b_reg})
                                       + $signed({prod_sh[31], prod_sh}));
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    numer_reg <= sat33($signed({d_reg[31], d_reg})
                                       - $signed({prod_sh[31], prod_sh}));
                    state_reg <= S_DIVV_GO;
                end
                S_DIVV_GO: state_reg <= S_DIVV;
                S_DIVV:
                begin
                    if (div_res.done)
                    begin
                        if (div_res.zero)
                            sing_reg <= 1'b1;
                        state_reg <= S_DIVU_GO;
                    end
                end
                S_DIVU_GO: state_reg <= S_DIVU;
                S_DIVU:
                begin
                    if (div_res.done)
                    begin
                        x_reg <= div_res.quot;
                        r_reg <= idx_reg;
                        if (!last_reg && idx_reg != IW'(DEPTH - 1))
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ovf_reg   <= !last_reg;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (sol_out.ready)
                    begin
                        if (r_reg == '0)
                        begin
                            // run done: drop row count and sticky flag
                            idx_reg   <= '0;
                            sing_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            r_reg     <= r_reg - 1'b1;
                            state_reg <= S_BRD;
                        end
                    end
                end
                S_BRD:  state_reg <= S_BMUL;
                S_BMUL: state_reg <= S_BADD;
                S_BADD:
                begin
                    x_reg <= sat33($signed({prod_sh[31], prod_sh})
                                   + $signed({off_rd_reg[31], off_rd_reg}));
                    state_reg <= S_EMIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Hold the row request payload for the whole forward step.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && row_in.valid)
        begin
            a_reg    <= row_in.sub_diag;
            b_reg    <= row_in.main_diag;
            c_reg    <= row_in.super_diag;
            d_reg    <= row_in.rhs;
            last_reg <= row_in.last_row;
        end
    end

    assign row_in.ready        = (state_reg == S_IDLE);
    assign sol_out.valid       = (state_reg == S_EMIT);
    assign sol_out.row_index   = ROW_IDX_W'(r_reg);
    assign sol_out.solution    = x_reg;
    assign sol_out.last_result = (r_reg == '0);
    assign sol_out.singular    = sing_reg;
    assign sol_out.overflow    = ovf_reg;

endmodule
`default_nettype wire

// ----- rtl/tds_divider.sv -----
// Radix-2 restoring fixed-point divider, one quotient bit per cycle.
// Depends on tds_pkg (div_res_t, saturation limits).
`default_nettype none
module tds_divider
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] num,
    input  wire logic signed [31:0] den,
    output div_res_t                res
);
    localparam int W  = 32 + FRAC_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  dvd_reg, dvd_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          neg_reg, nneg_reg, zero_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;
    logic [32:0] num_mag;
    logic [31:0] den_mag;

    always_comb
    begin
        num_mag = num[32] ? 33'(-num) : 33'(num);
        den_mag = den[31] ? 32'(-den) : 32'(den);
        trial   = {rem_reg, dvd_reg[W-1]};
        diff    = trial - {1'b0, den_reg};
        qbit    = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[31:0] : trial[31:0];
        dvd_next = {dvd_reg[W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den_mag;
            neg_reg  <= num[32] ^ den[31];
            nneg_reg <= num[32];
            zero_reg <= (den == '0);
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        res.done = done_reg;
        res.zero = zero_reg;
        if (zero_reg)
            res.quot = nneg_reg ? SAT_MIN : SAT_MAX;
        else if (neg_reg)
            res.quot = (dvd_reg > W'(64'h8000_0000)) ? SAT_MIN : 32'(-dvd_reg[31:0]);
        else
            res.quot = (dvd_reg > W'(64'h7FFF_FFFF)) ? SAT_MAX : dvd_reg[31:0];
    end

endmodule
`default_nettype wire

// ----- rtl/tds_checker.sv -----
// Port-level assertions for the tridiagonal solver, bound to the top level.
// Depends on tridiagonal_system_solver and tds_if.
`default_nettype none
module tds_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_last,
    input wire logic [4:0] out_row
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("row request taken while a result is pending");

    a_busy_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held through a row request");

    a_last_is_row0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_row == 5'd0)
        else $error("final result not on row zero");
endmodule

bind tridiagonal_system_solver tds_checker u_tds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (row_in.valid),
    .in_ready  (row_in.ready),
    .out_valid (sol_out.valid),
    .out_ready (sol_out.ready),
    .out_last  (sol_out.last_result),
    .out_row   (sol_out.row_index)
);
`default_nettype wire

// ----- dv/tridiagonal_system_solver_tb.sv -----
// Self-checking testbench for the tridiagonal system solver: drives rows over
// the row channel, predicts every solution value and checks the result channel.
// Depends on tds_pkg, tds_if and the solver RTL.
`default_nettype none
module tridiagonal_system_solver_tb;
    import tds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS  = DEPTH_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int LIMIT  = 4000000;

    typedef struct {
        logic [4:0]         row_index;
        logic signed [31:0] solution;
        logic               last_result;
        logic               singular;
        logic               overflow;
    } sol_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    tds_row_if row_ch();
    tds_sol_if sol_ch();

    tridiagonal_system_solver DUT (
        .clk(clk), .rst_n(rst_n), .row_in(row_ch.sink), .sol_out(sol_ch.source)
    );

    always #10 clk = ~clk;

    // prediction state
    longint factor_q[NROWS];
    longint offset_q[NROWS];
    int     rows_held;
    bit     pivot_zero_seen;
    sol_t   pending_sols[$];

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    function automatic longint sat(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return sat((a * b) >>> FRAC);
    endfunction

    function automatic longint fdiv(input longint num, input longint den, inout bit z);
        if (den == 0)
        begin
            z = 1'b1;
            return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end
        return sat((num * (64'sd1 <<< FRAC)) / den);
    endfunction

    task automatic solve_row(input logic signed [31:0] a, b, c, d, input logic last);
        int i;
        longint pv, nm, x;
        bit z;
        bit full;
        int n;
        sol_t s;
        i = rows_held;
        z = 1'b0;
        if (i == 0)
        begin
            pv = b;
            nm = d;
        end
        else
        begin
            pv = sat(longint'(b) + fmul(a, factor_q[i-1]));
            nm = sat(longint'(d) - fmul(a, offset_q[i-1]));
        end
        factor_q[i] = fdiv(-longint'(c), pv, z);
        offset_q[i] = fdiv(nm, pv, z);
        if (z)
            pivot_zero_seen = 1'b1;
        full = (i == NROWS - 1);
        if (!last && !full)
        begin
            rows_held = i + 1;
            return;
        end
        n = i + 1;
        x = offset_q[n-1];
        for (int k = 0; k < n; k++)
        begin
            int r;
            r = n - 1 - k;
            if (k > 0)
                x = sat(fmul(factor_q[r], x) + offset_q[r]);
            s.row_index = r[4:0];
            s.solution = x[31:0];
            s.last_result = (r == 0);
            s.singular = pivot_zero_seen;
            s.overflow = full && !last;
            pending_sols = {pending_sols, s};
        end
        rows_held = 0;
        pivot_zero_seen = 1'b0;
    endtask

    initial
    begin
        row_ch.valid = 1'b0;
        row_ch.sub_diag = '0;
        row_ch.main_diag = '0;
        row_ch.super_diag = '0;
        row_ch.rhs = '0;
        row_ch.last_row = 1'b0;
        sol_ch.ready = 1'b0;
    end

    task automatic send_row(input logic signed [31:0] a, b, c, d, input logic last);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        row_ch.valid <= 1'b1;
        row_ch.sub_diag <= a;
        row_ch.main_diag <= b;
        row_ch.super_diag <= c;
        row_ch.rhs <= d;
        row_ch.last_row <= last;
        @(posedge clk);
        while (!row_ch.ready)
            @(posedge clk);
        solve_row(a, b, c, d, last);
        row_ch.valid <= 1'b0;
        // the block stays busy after a request, so step past this edge
        @(posedge clk);
    endtask

    // result side: ready driven at each edge, checked on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sol_ch.valid && sol_ch.ready)
            begin
                if (pending_sols.size() == 0)
                begin
                    $display("%t unexpected result row %0d sol %h", $time,
                             sol_ch.row_index, sol_ch.solution);
                    errors++;
                end
                else
                begin
                    sol_t e;
                    e = pending_sols.pop_front();
                    if (e.row_index !== sol_ch.row_index || e.solution !== sol_ch.solution
                        || e.last_result !== sol_ch.last_result
                        || e.singular !== sol_ch.singular
                        || e.overflow !== sol_ch.overflow)
                    begin
                        $display("%t mismatch exp row %0d sol %h last %b sing %b ovf %b",
                                 $time, e.row_index, e.solution, e.last_result,
                                 e.singular, e.overflow);
                        $display("%t          act row %0d sol %h last %b sing %b ovf %b",
                                 $time, sol_ch.row_index, sol_ch.solution,
                                 sol_ch.last_result, sol_ch.singular, sol_ch.overflow);
                        errors++;
                    end
                end
            end
            sol_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // send a well-conditioned system of n rows
    task automatic send_system(input int n);
        for (int r = 0; r < n; r++)
        begin
            logic signed [31:0] a, c, b, d;
            a = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            c = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            b = 32'sh0003_0000 + $signed($urandom_range(32'h0004_0000));
            if ($urandom_range(1))
                b = -b;
            d = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(32'h0010_0000))
                - 32'sh0008_0000;
            send_row(a, b, c, d, r == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_sols.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic test_directed();
        send_row(32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 1'b1);
        send_row(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // zero pivot on first row, then positive and negative numerators
        send_row(32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_row(32'sh0001_0000, 32'sh0002_0000, 32'sh0, -32'sh0001_0000, 1'b1);
        send_row(32'sh0, 32'sh0, 32'sh0, -32'sh0001_0000, 1'b1);
        // singular flag must clear after the run
        send_row(32'sh1234_5678, 32'sh0001_0000, 32'sh0, 32'sh0003_0000, 1'b1);
        send_row(32'sh0, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        drain();
        // fill the store with no last row
        for (int r = 0; r < NROWS; r++)
            send_row(32'sh0000_4000, 32'sh0004_0000, 32'sh0000_4000, r << 16, 1'b0);
        drain();
    endtask

    task automatic test_random(input int nitems);
        int sent;
        sent = 0;
        while (sent < nitems)
        begin
            if ($urandom_range(9) < 7)
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(32, 20) : $urandom_range(6, 1);
                send_system(n);
                sent += n;
            end
            else
            begin
                send_row(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         $urandom_range(2) == 0);
                sent++;
            end
        end
        // close any open run
        send_row(32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_system(4);
                send_system(3);
            end
        join
        drain();
    endtask

    initial
    begin
        rows_held = 0;
        pivot_zero_seen = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(60);
        send_idle_pct = 80; recv_stall_pct = 0;  test_random(50);
        send_idle_pct = 0;  recv_stall_pct = 80; test_random(60);
        send_idle_pct = 26; recv_stall_pct = 26; test_random(60);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/tds_pkg.sv
rtl/tds_if.sv
rtl/tds_divider.sv
rtl/tridiagonal_system_solver.sv
rtl/tds_checker.sv
dv/tridiagonal_system_solver_tb.sv
